/* hw/rtl/md4_pkg.sv */
// Shared types, constants and step tables of the MD4 hash engine.
package md4_pkg;

  typedef logic [31:0] word_t;
  typedef logic [5:0]  step_t;
  typedef logic [3:0]  widx_t;

  // Initial chaining values and round constants.
  localparam word_t IV0 = 32'h67452301;
  localparam word_t IV1 = 32'hEFCDAB89;
  localparam word_t IV2 = 32'h98BADCFE;
  localparam word_t IV3 = 32'h10325476;
  localparam word_t K1  = 32'h5A827999;
  localparam word_t K2  = 32'h6ED9EBA1;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam step_t      LAST_STEP = 6'd47;

  // Round selector taken from the top bits of the step number.
  localparam logic [1:0] RND_F = 2'd0;
  localparam logic [1:0] RND_G = 2'd1;

  // Overlay applied to message words while the padded tail is compressed.
  typedef struct packed {
    logic  mask;      // words above pad_word read as zero
    logic  zero_all;  // every word reads as zero, but len_en words
    logic  len_en;    // words 14 and 15 read as the bit length
    widx_t pad_word;  // word that holds the 0x80 marker
  } msk_t;

  // Message word used by a step: straight, column order, then bit-reversed.
  function automatic widx_t word_idx(input step_t s);
    widx_t r;
    unique case (s[5:4])
      RND_F:   r = s[3:0];
      RND_G:   r = {s[1:0], s[3:2]};
      default: r = {s[0], s[1], s[2], s[3]};
    endcase
    return r;
  endfunction

  // Left rotation amount of a step.
  function automatic logic [4:0] rot_amt(input step_t s);
    logic [4:0] r;
    case ({s[5:4], s[1:0]})
      4'b0000: r = 5'd3;
      4'b0001: r = 5'd7;
      4'b0010: r = 5'd11;
      4'b0011: r = 5'd19;
      4'b0100: r = 5'd3;
      4'b0101: r = 5'd5;
      4'b0110: r = 5'd9;
      4'b0111: r = 5'd13;
      4'b1000: r = 5'd3;
      4'b1001: r = 5'd9;
      4'b1010: r = 5'd11;
      default: r = 5'd15;
    endcase
    return r;
  endfunction

  // Byte reversal so that the first digest byte lands in the top bits.
  function automatic word_t bswap(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

/* hw/rtl/md4_if.sv */
// Valid/ready channel interfaces for message bytes and digest results.
interface md4_msg_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] data_byte;
  logic       last_item;

  modport source (output valid, output byte_valid, output data_byte, output last_item,
                  input ready);
  modport sink (input valid, input byte_valid, input data_byte, input last_item,
                output ready);
endinterface

interface md4_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;

  modport source (output valid, output digest_word0, output digest_word1,
                  output digest_word2, output digest_word3, input ready);
  modport sink (input valid, input digest_word0, input digest_word1,
                input digest_word2, input digest_word3, output ready);
endinterface

/* hw/rtl/md4_msg_ram.sv */
// Sixteen-word message block memory with registered read and padding overlay.
module md4_msg_ram (
  input  logic          clk,
  input  logic          we,
  input  md4_pkg::widx_t waddr,
  input  md4_pkg::word_t wdata,
  input  md4_pkg::widx_t raddr,
  input  md4_pkg::msk_t  msk,
  input  logic [63:0]   bit_len,
  output md4_pkg::word_t rdata
);

  md4_pkg::word_t mem [16];
  md4_pkg::word_t rd_q;
  md4_pkg::widx_t idx_q;

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the index is kept for the overlay.
  always_ff @(posedge clk) begin
    rd_q  <= mem[raddr];
    idx_q <= raddr;
  end

  // Padding overlay: zero fill past the marker word or of the whole block, and the length in the last two words.
  always_comb begin
    if (msk.len_en && idx_q == 4'd14) begin
      rdata = bit_len[31:0];
    end else if (msk.len_en && idx_q == 4'd15) begin
      rdata = bit_len[63:32];
    end else if (msk.zero_all) begin
      rdata = '0;
    end else if (msk.mask && idx_q > msk.pad_word) begin
      rdata = '0;
    end else begin
      rdata = rd_q;
    end
  end

endmodule

/* hw/rtl/md4_round.sv */
// One MD4 step: round function, additions and rotation of the working word.
module md4_round (
  input  logic [3:0][31:0] wk,
  input  md4_pkg::step_t   step,
  input  md4_pkg::word_t   m,
  output logic [1:0]       a_sel,
  output md4_pkg::word_t   a_new
);

  md4_pkg::word_t b, c, d, f, k, sum;
  logic [63:0]    rot;

  // The target word rotates backwards through the four working words.
  assign a_sel = 2'(~step[1:0] + 2'd1);
  assign b     = wk[2'(a_sel + 2'd1)];
  assign c     = wk[2'(a_sel + 2'd2)];
  assign d     = wk[2'(a_sel + 2'd3)];

  // Round function and constant.
  always_comb begin
    unique case (step[5:4])
      md4_pkg::RND_F: begin
        f = (b & c) | (~b & d);
        k = '0;
      end
      md4_pkg::RND_G: begin
        f = (b & c) | (b & d) | (c & d);
        k = md4_pkg::K1;
      end
      default: begin
        f = b ^ c ^ d;
        k = md4_pkg::K2;
      end
    endcase
  end

  assign sum   = wk[a_sel] + f + m + k;
  assign rot   = {sum, sum} << md4_pkg::rot_amt(step);
  assign a_new = rot[63:32];

endmodule

/* hw/rtl/md4_hash_engine.sv */
// MD4 hash engine top level: control sequencer, chaining state and result register.
//
// The msg channel takes one request per cycle while the engine is idle. A request
// carries at most one message byte (byte_valid) and may mark the end of the message
// (last_item). The dig channel returns the four digest words of a message, each
// with the first digest byte in its top bits.
// The 64th byte of a block starts a compression (one read setup, 48 steps, one
// chaining add), during which msg.ready is low; the block memory read port feeds
// one message word per step.
// A last request adds a state to write the 0x80 marker, then one compression, or
// two when the tail leaves no room for the length, then a load of the result
// register that raises dig.valid.
// Reset returns the chaining words to the initial values, clears the bit length and
// drops any pending result. A stalled dig receiver holds the result in its register;
// the engine keeps taking bytes and only waits at the next result load.
module md4_hash_engine (
  input  logic         clk,
  input  logic         rst,
  md4_msg_if.sink      msg,
  md4_dig_if.source    dig
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_CINIT = 6'b000100,
    ST_CSTEP = 6'b001000,
    ST_CDONE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t           state, state_next;
  md4_pkg::step_t   step;
  logic [3:0][31:0] wk;
  logic [3:0][31:0] chain;
  logic [63:0]      bit_len;
  md4_pkg::word_t   wbuf;
  logic             pend_last;
  md4_pkg::msk_t    msk;
  logic             out_valid;
  logic [3:0][31:0] out_word;

  logic             take;
  logic [5:0]       pos;
  logic [7:0]       lane_byte;
  md4_pkg::word_t   wnew;
  logic             mem_we;
  md4_pkg::widx_t   raddr;
  md4_pkg::word_t   rdata;
  logic [1:0]       a_sel;
  md4_pkg::word_t   a_new;
  logic             emit_load;

  assign take      = msg.valid && msg.ready;
  assign msg.ready = (state == ST_IDLE);
  assign pos       = bit_len[8:3];

  // Byte lane insert: lane zero starts a fresh word, other lanes merge into it.
  assign lane_byte = (state == ST_PAD) ? md4_pkg::PAD_BYTE : msg.data_byte;
  assign wnew      = (pos[1:0] == 2'd0) ? {24'd0, lane_byte}
                                        : wbuf | (32'(lane_byte) << {pos[1:0], 3'b000});
  assign mem_we    = (take && msg.byte_valid) || (state == ST_PAD);

  // Read address runs one step ahead of the round logic.
  assign raddr = (state == ST_CSTEP) ? md4_pkg::word_idx(6'(step + 6'd1))
                                     : md4_pkg::word_idx(6'd0);

  md4_msg_ram u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (pos[5:2]),
    .wdata   (wnew),
    .raddr   (raddr),
    .msk     (msk),
    .bit_len (bit_len),
    .rdata   (rdata)
  );

  md4_round u_round (
    .wk    (wk),
    .step  (step),
    .m     (rdata),
    .a_sel (a_sel),
    .a_new (a_new)
  );

  assign emit_load = (state == ST_EMIT) && (!out_valid || dig.ready);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && msg.byte_valid && pos == md4_pkg::LAST_POS) begin
          state_next = ST_CINIT;
        end else if (take && msg.last_item) begin
          state_next = ST_PAD;
        end
      end
      ST_PAD:   state_next = ST_CINIT;
      ST_CINIT: state_next = ST_CSTEP;
      ST_CSTEP: begin
        if (step == md4_pkg::LAST_STEP) begin
          state_next = ST_CDONE;
        end
      end
      ST_CDONE: begin
        if (!msk.mask && !msk.zero_all) begin
          state_next = pend_last ? ST_PAD : ST_IDLE;
        end else if (!msk.len_en) begin
          state_next = ST_CINIT;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      chain     <= {md4_pkg::IV3, md4_pkg::IV2, md4_pkg::IV1, md4_pkg::IV0};
      bit_len   <= '0;
      pend_last <= 1'b0;
      msk       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take && msg.byte_valid) begin
        bit_len <= bit_len + 64'd8;
      end
      if (take) begin
        pend_last <= msg.last_item;
        msk       <= '0;
      end
      // Marker write decides whether the length fits in this block.
      if (state == ST_PAD) begin
        pend_last <= 1'b0;
        msk       <= '{mask: 1'b1, zero_all: 1'b0, len_en: (pos < md4_pkg::LEN_POS),
                       pad_word: pos[5:2]};
      end
      if (state == ST_CSTEP) begin
        step <= (step == md4_pkg::LAST_STEP) ? 6'd0 : 6'(step + 6'd1);
      end
      if (state == ST_CDONE) begin
        for (int i = 0; i < 4; i++) begin
          chain[i] <= chain[i] + wk[i];
        end
        // A marker block without room for the length is followed by a length-only block.
        if (msk.mask && !msk.len_en) begin
          msk <= '{mask: 1'b0, zero_all: 1'b1, len_en: 1'b1, pad_word: msk.pad_word};
        end
      end
      if (emit_load) begin
        chain   <= {md4_pkg::IV3, md4_pkg::IV2, md4_pkg::IV1, md4_pkg::IV0};
        bit_len <= '0;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (dig.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working words, byte assembly buffer and result register.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wbuf <= wnew;
    end
    if (state == ST_CINIT) begin
      wk <= chain;
    end else if (state == ST_CSTEP) begin
      wk[a_sel] <= a_new;
    end
    if (emit_load) begin
      for (int i = 0; i < 4; i++) begin
        out_word[i] <= md4_pkg::bswap(chain[i]);
      end
    end
  end

  assign dig.valid        = out_valid;
  assign dig.digest_word0 = out_word[0];
  assign dig.digest_word1 = out_word[1];
  assign dig.digest_word2 = out_word[2];
  assign dig.digest_word3 = out_word[3];

`ifndef ASSERT_OFF
  // The step counter only moves during the step phase and never passes the last step.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (step <= md4_pkg::LAST_STEP) && (state == ST_CSTEP || step == 6'd0))
    else $error("step counter out of range");

  // The block memory is never written while a compression reads it.
  a_no_write_in_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CINIT || state == ST_CSTEP || state == ST_CDONE) |-> !mem_we)
    else $error("message write during compression");

  // The length-only block always carries the length.
  a_zero_has_len: assert property (@(posedge clk) disable iff (rst)
    msk.zero_all |-> msk.len_en)
    else $error("zero block without length");

  // A result load restarts the chain and the length for the next message.
  a_emit_restart: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> (bit_len == 64'd0) && (chain[0] == md4_pkg::IV0) && dig.valid)
    else $error("engine not restarted after result");

  // A result is only loaded after a compression of the padded tail.
  a_emit_after_tail: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_EMIT) |-> $past(state == ST_CDONE) && msk.len_en)
    else $error("result without padded tail");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking testbench of the MD4 hash engine, with a digest tracker and request drivers.
`timescale 1ns / 100ps

module testbench;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 120;
  localparam int MIN_REQUESTS = 650;
  localparam int MIN_MESSAGES = 16;

  // Tracks the chaining state of the engine and holds the digests still due.
  class md4_digest_tracker;
    md4_pkg::word_t chain[4];
    md4_pkg::word_t block_words[16];
    logic [63:0] bit_count;
    logic [127:0] expected_digests[$];
    int errors;
    int shifts[3][4] = '{'{3, 7, 11, 19}, '{3, 5, 9, 13}, '{3, 9, 11, 15}};

    function new();
      restart_chain();
      foreach (block_words[i]) block_words[i] = '0;
      errors = 0;
    endfunction

    function void restart_chain();
      chain[0] = md4_pkg::IV0;
      chain[1] = md4_pkg::IV1;
      chain[2] = md4_pkg::IV2;
      chain[3] = md4_pkg::IV3;
      bit_count = '0;
    endfunction

    // A byte lands in its lane; lanes above it are cleared.
    function void put_byte(int pos, logic [7:0] value);
      int w;
      int sh;
      w = (pos >> 2) & 15;
      sh = (pos & 3) * 8;
      block_words[w] = (block_words[w] & ((32'h1 << sh) - 32'h1)) |
                       (md4_pkg::word_t'(value) << sh);
    endfunction

    // Runs the 48 MD4 steps over the current block and folds them into the chain.
    function void compress_block();
      md4_pkg::word_t a, b, c, d, f, kc, acc;
      int rnd, n, widx, s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int i = 0; i < 48; i++) begin
        rnd = i / 16;
        n = i % 16;
        case (rnd)
          0: begin
            f = (b & c) | (~b & d);
            kc = '0;
            widx = n;
          end
          1: begin
            f = (b & c) | (b & d) | (c & d);
            kc = md4_pkg::K1;
            widx = (n % 4) * 4 + n / 4;
          end
          default: begin
            f = b ^ c ^ d;
            kc = md4_pkg::K2;
            widx = ((n & 1) << 3) | ((n & 2) << 1) | ((n & 4) >> 1) | ((n & 8) >> 3);
          end
        endcase
        acc = a + f + block_words[widx] + kc;
        s = shifts[rnd][i % 4];
        acc = (acc << s) | (acc >> (32 - s));
        // Rotate the roles so the next step targets the following word.
        a = d;
        d = c;
        c = b;
        b = acc;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    // Applies one accepted request and queues the digest it produces, if any.
    function void note_request(bit bv, logic [7:0] data, bit last);
      int pos;
      md4_pkg::word_t swapped[4];
      if (bv) begin
        pos = int'(bit_count[8:3]);
        put_byte(pos, data);
        bit_count += 64'd8;
        if (pos == int'(md4_pkg::LAST_POS)) compress_block();
      end
      if (!last) return;
      pos = int'(bit_count[8:3]);
      put_byte(pos, md4_pkg::PAD_BYTE);
      for (int i = (pos >> 2) + 1; i < 16; i++) block_words[i] = '0;
      // With no room left for the length, the tail takes a block of its own.
      if (pos >= int'(md4_pkg::LEN_POS)) begin
        compress_block();
        foreach (block_words[i]) block_words[i] = '0;
      end
      block_words[14] = bit_count[31:0];
      block_words[15] = bit_count[63:32];
      compress_block();
      foreach (chain[i]) swapped[i] = {<<8{chain[i]}};
      expected_digests.push_back({swapped[0], swapped[1], swapped[2], swapped[3]});
      restart_chain();
    endfunction

    // Compares one returned digest with the oldest one due.
    function void check_digest(md4_pkg::word_t w0, md4_pkg::word_t w1,
                               md4_pkg::word_t w2, md4_pkg::word_t w3);
      logic [127:0] exp_digest;
      md4_pkg::word_t got[4];
      md4_pkg::word_t want;
      got = '{w0, w1, w2, w3};
      if (expected_digests.size() == 0) begin
        $display("%0t: digest %08h %08h %08h %08h returned with none expected, expected none",
                 $time, w0, w1, w2, w3);
        errors++;
        return;
      end
      exp_digest = expected_digests.pop_front();
      for (int i = 0; i < 4; i++) begin
        want = exp_digest[127 - 32 * i -: 32];
        if (got[i] !== want) begin
          $display("%0t: digest_word%0d mismatch, expected %08h, actual %08h",
                   $time, i, want, got[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit no_gaps;
  int requests_sent;
  int messages_sent;
  int boundary_lens[10] = '{55, 56, 57, 62, 63, 64, 65, 119, 120, 128};
  md4_digest_tracker tracker;

  md4_msg_if msg_ch ();
  md4_dig_if dig_ch ();

  md4_hash_engine uut (
    .clk (clk),
    .rst (rst),
    .msg (msg_ch),
    .dig (dig_ch)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Reset is held at the start of the run and then released.
  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Idle cycles before the next transfer; none while a burst phase is on.
  function automatic int pick_gap();
    return no_gaps ? 0 : int'($urandom_range(0, 4));
  endfunction

  // Offers one request and waits until the engine takes it.
  task automatic send_request(input bit bv, input logic [7:0] data, input bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.byte_valid <= bv;
    msg_ch.data_byte <= data;
    msg_ch.last_item <= last;
    do @(posedge clk); while (!msg_ch.ready);
    tracker.note_request(bv, data, last);
    requests_sent++;
    @(negedge clk);
  endtask

  // Sends a whole message; the end mark rides on the last byte or on an empty request.
  task automatic send_message(input int len, input bit tail_with_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_request(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      send_request(1'b1, 8'($urandom_range(0, 255)), tail_with_byte && (i == len - 1));
    end
    if (!tail_with_byte || len == 0) send_request(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    messages_sent++;
  endtask

  // Digest receiver with random stalls; every accepted digest is checked.
  initial begin
    int stall;
    dig_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        dig_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      dig_ch.ready <= 1'b1;
      do @(posedge clk); while (!dig_ch.valid);
      tracker.check_digest(dig_ch.digest_word0, dig_ch.digest_word1,
                           dig_ch.digest_word2, dig_ch.digest_word3);
      @(negedge clk);
    end
  end

  // Ends the run when neither channel has moved for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Main stimulus: directed cases, then random messages, then drain.
  initial begin
    int sel;
    int len;
    tracker = new();
    requests_sent = 0;
    messages_sent = 0;
    no_gaps = 1'b0;
    msg_ch.valid = 1'b0;
    msg_ch.byte_valid = 1'b0;
    msg_ch.data_byte = 8'h00;
    msg_ch.last_item = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);

    // Empty message, alone and after an idle request.
    send_request(1'b0, 8'h00, 1'b1);
    send_request(1'b0, 8'hFF, 1'b0);
    send_request(1'b0, 8'hFF, 1'b1);
    // Single bytes at both extremes, with the end mark on the byte and after it.
    send_request(1'b1, 8'h00, 1'b1);
    send_request(1'b1, 8'hFF, 1'b0);
    send_request(1'b0, 8'h00, 1'b0);
    send_request(1'b0, 8'h00, 1'b1);
    // Short text message and a pair of mid-range bytes.
    send_request(1'b1, 8'h61, 1'b0);
    send_request(1'b1, 8'h62, 1'b0);
    send_request(1'b1, 8'h63, 1'b1);
    send_request(1'b1, 8'h80, 1'b0);
    send_request(1'b1, 8'h7F, 1'b1);

    // Random messages, weighted toward short ones and block boundaries.
    requests_sent = 0;
    messages_sent = 0;
    while (requests_sent < MIN_REQUESTS || messages_sent < MIN_MESSAGES) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      sel = int'($urandom_range(0, 9));
      if (sel < 5) len = int'($urandom_range(0, 8));
      else if (sel < 7) len = boundary_lens[$urandom_range(0, 9)];
      else len = int'($urandom_range(9, 40));
      send_message(len, 1'($urandom_range(0, 1)));
    end
    no_gaps = 1'b0;
    msg_ch.valid <= 1'b0;

    // Wait for every digest, then watch a while for stray results.
    while (tracker.expected_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
